// ===== rtl/jld_pkg.sv =====
// Shared types, constants and a helper function for the jump landing detector.
`timescale 1ns / 1ps

package jld_pkg;

    // Configuration register map.
    localparam int CFG_IDX_BITS  = 1;
    localparam int CFG_DATA_BITS = 16;
    localparam int THRESHOLD_BITS = 8;
    localparam int HOLD_BITS      = 16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FORCE_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HOLD_MS         = 1'd1;

    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET = 8'd20;
    localparam logic [HOLD_BITS-1:0]      HOLD_RESET      = 16'd1000;

    // Phase codes as they appear on the result channel.
    localparam int PHASE_BITS = 3;
    localparam logic [PHASE_BITS-1:0] CODE_GROUND     = 3'd0;
    localparam logic [PHASE_BITS-1:0] CODE_MAYBE_JUMP = 3'd1;
    localparam logic [PHASE_BITS-1:0] CODE_AIR        = 3'd2;
    localparam logic [PHASE_BITS-1:0] CODE_MAYBE_LAND = 3'd3;
    localparam logic [PHASE_BITS-1:0] CODE_HOLD       = 3'd4;

    // Internal one-hot phase encoding.
    typedef enum logic [4:0] {
        PH_GROUND     = 5'b00001,
        PH_MAYBE_JUMP = 5'b00010,
        PH_AIR        = 5'b00100,
        PH_MAYBE_LAND = 5'b01000,
        PH_HOLD       = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [THRESHOLD_BITS-1:0] force_threshold;
        logic [HOLD_BITS-1:0]      hold_ms;
    } cfg_t;

    function automatic logic [PHASE_BITS-1:0] phase_code(input phase_t ph);
        logic [PHASE_BITS-1:0] code;
        unique case (ph)
            PH_GROUND:     code = CODE_GROUND;
            PH_MAYBE_JUMP: code = CODE_MAYBE_JUMP;
            PH_AIR:        code = CODE_AIR;
            PH_MAYBE_LAND: code = CODE_MAYBE_LAND;
            PH_HOLD:       code = CODE_HOLD;
            default:       code = CODE_GROUND;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/jld_if.sv =====
// Valid/ready channel interfaces for samples and detector results.
`timescale 1ns / 1ps

interface jld_sample_if #(
    parameter int SAMPLE_BITS = 8,
    parameter int TIME_BITS   = 32
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] force_sample;
    logic [TIME_BITS-1:0]   now_ms;

    modport source (output valid, output force_sample, output now_ms, input ready);
    modport sink   (input valid, input force_sample, input now_ms, output ready);
endinterface

interface jld_result_if #(
    parameter int SAMPLE_BITS = 8,
    parameter int TIME_BITS   = 32
);
    logic                   valid;
    logic                   ready;
    logic [2:0]             phase;
    logic                   jumped;
    logic                   landed;
    logic [TIME_BITS-1:0]   air_time_ms;
    logic [SAMPLE_BITS-1:0] peak_jump_force;
    logic [SAMPLE_BITS-1:0] peak_land_force;

    modport source (
        output valid, output phase, output jumped, output landed,
        output air_time_ms, output peak_jump_force, output peak_land_force,
        input ready
    );
    modport sink (
        input valid, input phase, input jumped, input landed,
        input air_time_ms, input peak_jump_force, input peak_land_force,
        output ready
    );
endinterface

// ===== rtl/jld_cfg.sv =====
// Configuration register file for the threshold and hold window.
`timescale 1ns / 1ps

module jld_cfg
    import jld_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    output cfg_t                     cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FORCE_THRESHOLD: cfg_next.force_threshold = cfg_wdata[THRESHOLD_BITS-1:0];
                CFG_HOLD_MS:         cfg_next.hold_ms = cfg_wdata[HOLD_BITS-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.force_threshold <= THRESHOLD_RESET;
            cfg_reg.hold_ms         <= HOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/jld_core.sv =====
// Detector phase machine and state registers, updated once per accepted sample.
`timescale 1ns / 1ps

module jld_core
    import jld_pkg::*;
#(
    parameter int SAMPLE_BITS = 8,
    parameter int TIME_BITS   = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   step_en,
    input  logic [SAMPLE_BITS-1:0] force_sample,
    input  logic [TIME_BITS-1:0]   now_ms,
    output logic [PHASE_BITS-1:0]  phase,
    output logic                   jumped,
    output logic                   landed,
    output logic [TIME_BITS-1:0]   air_time_ms,
    output logic [SAMPLE_BITS-1:0] peak_jump_force,
    output logic [SAMPLE_BITS-1:0] peak_land_force
);

    // Compare width covers both the sample and the fixed 8-bit threshold.
    localparam int CMP_BITS = (SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS;

    phase_t                 phase_reg,     phase_next;
    logic [TIME_BITS-1:0]   takeoff_reg,   takeoff_next;
    logic [TIME_BITS-1:0]   landing_reg,   landing_next;
    logic [TIME_BITS-1:0]   air_time_reg,  air_time_next;
    logic [SAMPLE_BITS-1:0] jump_peak_reg, jump_peak_next;
    logic [SAMPLE_BITS-1:0] land_peak_reg, land_peak_next;
    logic                   jumped_reg,    jumped_next;
    logic                   landed_reg,    landed_next;

    logic [CMP_BITS-1:0]  sample_ext;
    logic [CMP_BITS-1:0]  threshold_ext;
    logic                 below;
    logic                 above;
    logic [TIME_BITS-1:0] since_landing;
    logic                 in_hold_window;

    assign sample_ext     = CMP_BITS'(force_sample);
    assign threshold_ext  = CMP_BITS'(cfg.force_threshold);
    assign below          = sample_ext < threshold_ext;
    assign above          = sample_ext > threshold_ext;
    assign since_landing  = now_ms - landing_reg;
    assign in_hold_window = since_landing < TIME_BITS'(cfg.hold_ms);

    always_comb
    begin
        phase_next     = phase_reg;
        takeoff_next   = takeoff_reg;
        landing_next   = landing_reg;
        air_time_next  = air_time_reg;
        jump_peak_next = jump_peak_reg;
        land_peak_next = land_peak_reg;
        jumped_next    = jumped_reg;
        landed_next    = landed_reg;

        unique case (phase_reg)
            PH_GROUND:
            begin
                if (force_sample > jump_peak_reg)
                    jump_peak_next = force_sample;
                if (below)
                    phase_next = PH_MAYBE_JUMP;
            end
            PH_MAYBE_JUMP:
            begin
                if (force_sample > jump_peak_reg)
                    jump_peak_next = force_sample;
                if (below)
                begin
                    phase_next   = PH_AIR;
                    takeoff_next = now_ms;
                    jumped_next  = 1'b1;
                end
                else
                begin
                    phase_next = PH_GROUND;
                end
            end
            PH_AIR:
            begin
                if (above)
                    phase_next = PH_MAYBE_LAND;
            end
            PH_MAYBE_LAND:
            begin
                if (above)
                begin
                    phase_next    = PH_HOLD;
                    air_time_next = now_ms - takeoff_reg;
                    landing_next  = now_ms;
                    landed_next   = 1'b1;
                    if (force_sample > land_peak_reg)
                        land_peak_next = force_sample;
                end
                else
                begin
                    phase_next = PH_AIR;
                end
            end
            PH_HOLD:
            begin
                if (in_hold_window)
                begin
                    if (force_sample > land_peak_reg)
                        land_peak_next = force_sample;
                end
                else
                begin
                    phase_next = PH_GROUND;
                end
            end
            default:
            begin
                phase_next = PH_GROUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_GROUND;
            takeoff_reg   <= '0;
            landing_reg   <= '0;
            air_time_reg  <= '0;
            jump_peak_reg <= '0;
            land_peak_reg <= '0;
            jumped_reg    <= 1'b0;
            landed_reg    <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg     <= phase_next;
            takeoff_reg   <= takeoff_next;
            landing_reg   <= landing_next;
            air_time_reg  <= air_time_next;
            jump_peak_reg <= jump_peak_next;
            land_peak_reg <= land_peak_next;
            jumped_reg    <= jumped_next;
            landed_reg    <= landed_next;
        end
    end

    assign phase           = phase_code(phase_reg);
    assign jumped          = jumped_reg;
    assign landed          = landed_reg;
    assign air_time_ms     = air_time_reg;
    assign peak_jump_force = jump_peak_reg;
    assign peak_land_force = land_peak_reg;

endmodule

// ===== rtl/jump_landing_detector.sv =====
// Top level of the jump landing detector: input register, detector core, result handshake.
`timescale 1ns / 1ps

// The block watches a stream of force samples, each item carrying a sample and a
// free-running millisecond timestamp, and reports one result item per sample: the
// detector phase, the sticky jumped and landed flags, the last air time and the
// take-off and landing force peaks.
// Each accepted sample is first captured in an input register. When the result
// slot can take it, the phase machine evaluates it (a few compares and two
// subtractions) and writes the detector state, which itself serves as the result
// register, together with the result valid flag. One item is taken every cycle as
// long as the receiver takes results, so the sustained rate is one item per cycle.
// When the receiver stalls, the result holds and one more sample may wait in the
// input register; the sample channel then drops ready until the result is taken.
// The force threshold and hold window are written through cfg_we, cfg_index and
// cfg_wdata, one register per write; the user must write them only while no item
// is in flight, which the block does not enforce. Reset clears all detector state
// to the ground phase with zero peaks, times and flags, loads the threshold with 20
// and the hold window with 1000 ms, and empties the input register and result slot.
module jump_landing_detector
    import jld_pkg::*;
#(
    parameter int SAMPLE_BITS = 8,
    parameter int TIME_BITS   = 32
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    jld_sample_if.sink               sample_in,
    jld_result_if.source             result_out
);

    cfg_t cfg;

    // Input register stage.
    logic                   in_valid_reg, in_valid_next;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic [TIME_BITS-1:0]   in_now_reg;

    // Result slot occupancy; the payload lives in the core state registers.
    logic out_valid_reg, out_valid_next;

    logic step_en;
    logic in_accept;

    jld_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held sample advances into the state only when the result slot is free
    // or is being emptied in the same cycle.
    assign step_en   = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign sample_in.ready = !in_valid_reg || step_en;
    assign in_accept = sample_in.valid && sample_in.ready;

    always_comb
    begin
        in_valid_next  = in_accept || (in_valid_reg && !step_en);
        out_valid_next = step_en || (out_valid_reg && !result_out.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_sample_reg <= sample_in.force_sample;
            in_now_reg    <= sample_in.now_ms;
        end
    end

    jld_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .step_en         (step_en),
        .force_sample    (in_sample_reg),
        .now_ms          (in_now_reg),
        .phase           (result_out.phase),
        .jumped          (result_out.jumped),
        .landed          (result_out.landed),
        .air_time_ms     (result_out.air_time_ms),
        .peak_jump_force (result_out.peak_jump_force),
        .peak_land_force (result_out.peak_land_force)
    );

    assign result_out.valid = out_valid_reg;

    // The jumped flag never clears once set.
    a_jumped_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.jumped |=> result_out.jumped)
        else $error("jumped flag cleared");

    // A landing can only be confirmed after a take-off.
    a_landed_after_jump: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.landed |-> result_out.jumped)
        else $error("landed set without jumped");

    // A held sample that cannot advance is kept, not dropped.
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step_en) |=> in_valid_reg)
        else $error("waiting sample lost");

    // An evaluated sample always produces a visible result in the next cycle.
    a_step_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> result_out.valid)
        else $error("result missing after step");

endmodule
